/* hw/rtl/bsfh_pkg.sv */
`timescale 1ns / 1ps
package bsfh_pkg;

	// frame store geometry
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 512;
	localparam int PIXEL_BITS = 24;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);

	// raster and size widths
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);

	// configuration port, fixed by the register list
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int FW_W       = 11;
	localparam int FH_W       = 10;
	localparam int BS_W       = 11;

	// cursor sums must hold a coordinate plus a full block side
	localparam int SUM_W = ((COL_W > BS_W) ? COL_W : BS_W) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

	localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
	localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 10'd480;
	localparam logic [BS_W-1:0] RST_BLOCK_SIZE   = 11'd32;
	localparam logic [BS_W-1:0] DEFAULT_BLOCK    = 11'd32;

	// effective frame geometry after clamping
	typedef struct packed {
		logic [WW-1:0]   w;
		logic [HW-1:0]   h;
		logic [BS_W-1:0] bs;
	} geom_t;

	// per-word decision for the current raster position
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              in_win;
		logic              last;
	} pos_t;

endpackage

/* hw/rtl/block_sweep_frame_hold_top.sv */
`timescale 1ns / 1ps
// Frame-hold video effect that refreshes one square block of a held frame per frame.
// Input channel (in_valid / in_stall) takes one raster word per cycle unless stalled: pixel_in and
// frame_start, which puts the raster back to the top-left corner. Output channel
// (out_valid / out_stall) returns one word per input word: the held pixel and
// frame_end on the last pixel of each frame. Configuration (cfg_valid / cfg_ready,
// always ready) writes frame_width, frame_height and block_size by cfg_index 0..2;
// write only while no words are in flight.
// An accepted word moves through the read stage into the output register, raising
// out_valid. Throughput: one word per cycle while no stall holds it, set by the single
// frame-store access (a write inside the block window, a read elsewhere) that each word makes.
// Reset: the frame store is swept to zero, one entry a cycle, over all 524288 entries;
// in_stall stays high during the sweep while configuration writes are taken.
// When the receiver stalls, the output word holds and one more word can enter the
// read stage; after that in_stall rises until the output drains.
module block_sweep_frame_hold_top import bsfh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIXEL_BITS-1:0] pixel_in,
	input  logic                  frame_start,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIXEL_BITS-1:0] pixel_out,
	output logic                  frame_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	geom_t geom;
	pos_t  pos;

	logic                  accept;
	logic                  out_free;
	logic                  s1_adv;
	logic                  clearing_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [PIXEL_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [PIXEL_BITS-1:0] ram_rdata;
	logic                  valid_s1;
	logic                  inside_s1;
	logic                  last_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] pixel_out_q;
	logic                  frame_end_q;

	assign cfg_ready = 1'b1;

	bsfh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	bsfh_cursor u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.advance     (accept),
		.frame_start (frame_start),
		.pos         (pos)
	);

	// handshake: stall during the sweep or when the read stage cannot move
	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = valid_s1 && out_free;
	assign in_stall = clearing_q || (valid_s1 && !out_free);
	assign accept   = in_valid && !in_stall;

	// sweep the store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// store access: write live pixels inside the window, read elsewhere
	always_comb begin
		ram_we    = clearing_q || (accept && pos.in_win);
		ram_waddr = clearing_q ? clr_addr_q : pos.addr;
		ram_wdata = clearing_q ? '0 : pixel_in;
		ram_re    = accept && !pos.in_win;
	end

	bsfh_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (PIXEL_BITS),
		.DEPTH  (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pos.addr),
		.rdata (ram_rdata)
	);

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			inside_s1 <= pos.in_win;
			last_s1   <= pos.last;
			pix_s1    <= pixel_in;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload: pick live pixel or stored pixel
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_out_q <= inside_s1 ? pix_s1 : ram_rdata;
			frame_end_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;

endmodule

/* hw/rtl/bsfh_ram.sv */
`timescale 1ns / 1ps
module bsfh_ram #(
	parameter int ADDR_W = 19,
	parameter int DATA_W = 24,
	parameter int DEPTH  = 524288
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/bsfh_cfg.sv */
`timescale 1ns / 1ps
module bsfh_cfg import bsfh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output geom_t                 geom
);

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [BS_W-1:0] block_size_q;

	// capture register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			block_size_q   <= RST_BLOCK_SIZE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_BLOCK_SIZE:   block_size_q   <= cfg_data[BS_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp sizes into the store and map a zero block to the default
	always_comb begin
		if (frame_width_q == '0) begin
			geom.w = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			geom.w = WW'(MAX_WIDTH);
		end else begin
			geom.w = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			geom.h = HW'(1);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			geom.h = HW'(MAX_HEIGHT);
		end else begin
			geom.h = HW'(frame_height_q);
		end
		geom.bs = (block_size_q == '0) ? DEFAULT_BLOCK : block_size_q;
	end

endmodule

/* hw/rtl/bsfh_cursor.sv */
`timescale 1ns / 1ps
module bsfh_cursor import bsfh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  geom_t geom,
	input  logic  advance,
	input  logic  frame_start,
	output pos_t  pos
);

	logic [COL_W-1:0] raster_col_q;
	logic [ROW_W-1:0] raster_row_q;
	logic [COL_W-1:0] cursor_col_q;
	logic [ROW_W-1:0] cursor_row_q;

	logic [WW-1:0]    c0;
	logic [HW-1:0]    r0;
	logic [COL_W-1:0] c;
	logic [ROW_W-1:0] r;
	logic [WW-1:0]    col_inc;
	logic [HW-1:0]    row_inc;
	logic [SUM_W-1:0] cur_col_end;
	logic [SUM_W-1:0] cur_row_end;
	logic [COL_W-1:0] raster_col_d;
	logic [ROW_W-1:0] raster_row_d;
	logic [COL_W-1:0] cursor_col_d;
	logic [ROW_W-1:0] cursor_row_d;

	// resolve the position of this word, wrapping past a shrunken frame
	always_comb begin
		c0 = frame_start ? '0 : WW'(raster_col_q);
		r0 = frame_start ? '0 : HW'(raster_row_q);
		if (c0 >= geom.w) begin
			c0 = '0;
			r0 = r0 + HW'(1);
		end
		if (r0 >= geom.h) begin
			r0 = '0;
		end
		c = c0[COL_W-1:0];
		r = r0[ROW_W-1:0];
	end

	// window test, frame end and store address
	always_comb begin
		cur_col_end = SUM_W'(cursor_col_q) + SUM_W'(geom.bs);
		cur_row_end = SUM_W'(cursor_row_q) + SUM_W'(geom.bs);
		pos.in_win  = (c >= cursor_col_q) && (SUM_W'(c) < cur_col_end) &&
		              (r >= cursor_row_q) && (SUM_W'(r) < cur_row_end);
		pos.last    = (WW'(c) == geom.w - WW'(1)) && (HW'(r) == geom.h - HW'(1));
		pos.addr    = ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
	end

	// advance raster and, at frame end, the block cursor
	always_comb begin
		col_inc      = WW'(c) + WW'(1);
		row_inc      = HW'(r) + HW'(1);
		raster_col_d = col_inc[COL_W-1:0];
		raster_row_d = r;
		if (col_inc >= geom.w) begin
			raster_col_d = '0;
			raster_row_d = (row_inc >= geom.h) ? '0 : row_inc[ROW_W-1:0];
		end
		cursor_col_d = cursor_col_q;
		cursor_row_d = cursor_row_q;
		if (pos.last) begin
			if (cur_col_end >= SUM_W'(geom.w)) begin
				cursor_col_d = '0;
				cursor_row_d = (cur_row_end >= SUM_W'(geom.h)) ? '0
				             : cur_row_end[ROW_W-1:0];
			end else begin
				cursor_col_d = cur_col_end[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_col_q <= '0;
			raster_row_q <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (advance) begin
			raster_col_q <= raster_col_d;
			raster_row_q <= raster_row_d;
			cursor_col_q <= cursor_col_d;
			cursor_row_q <= cursor_row_d;
		end
	end

endmodule

/* hw/rtl/bsfh_checker.sv */
`timescale 1ns / 1ps
module bsfh_checker import bsfh_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [PIXEL_BITS-1:0] pixel_in,
	input logic                  frame_start,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [PIXEL_BITS-1:0] pixel_out,
	input logic                  frame_end
);

	// hold a stalled output word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_end))
		else $error("stalled output word changed");

	// hold a stalled input word
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(pixel_in) && $stable(frame_start))
		else $error("stalled input word changed");

	// stall input right after reset, as the store sweep begins
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("input taken before store sweep finished");

	// a fresh output word comes from an accepted word that passed through the read stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output word without matching input");

	// one word of slack behind a stalled output, then stall
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && $past(in_valid && !in_stall) &&
		$past(out_valid && out_stall) |-> in_stall)
		else $error("input taken with no room behind stalled output");

endmodule

bind block_sweep_frame_hold_top bsfh_checker u_bsfh_checker (.*);
